// ===== sv/lru_frame_replacer_macros.svh =====
// assertion macros for the lru frame replacer
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef LRU_FRAME_REPLACER_MACROS_SVH
`define LRU_FRAME_REPLACER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lru frame replacer assertion failed");
`define LFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru frame replacer implication failed");
`else
`define LFR_ASSERT(lbl, prop)
`define LFR_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== sv/lfr_pkg.sv =====
// shared types and constants of the lru frame replacer
// no dependencies
package lfr_pkg;

  localparam int FRAME_W = 6;
  localparam int REQ_W   = 2;

  localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIN    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNPIN  = 2'd2;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic               cmp;
    logic [FRAME_W-1:0] cmp_frame;
    logic               append;
    logic [FRAME_W-1:0] app_frame;
  } cell_ctrl_t;

endpackage

// ===== sv/lfr_cell.sv =====
// one list cell: holds a frame id, compares it, loads an appended id or shifts from its newer neighbor
// depends on lfr_pkg
module lfr_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lfr_pkg::cell_ctrl_t         ctrl_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic                        shift_i,
  input  logic [lfr_pkg::FRAME_W-1:0] next_id_i,
  output logic [lfr_pkg::FRAME_W-1:0] id_o,
  output logic                        hit_o
);
  import lfr_pkg::*;

  logic [FRAME_W-1:0] id_q;
  logic               hit_q;
  logic               listed;
  logic               load;

  assign listed = CNT_W'(IDX) < count_i;
  assign load   = ctrl_i.append && (count_i == CNT_W'(IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      hit_q <= listed && (id_q == ctrl_i.cmp_frame);
    end
  end

  // payload, undefined until written
  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q <= ctrl_i.app_frame;
    end else if (shift_i) begin
      id_q <= next_id_i;
    end
  end

  assign id_o  = id_q;
  assign hit_o = hit_q;

endmodule

// ===== sv/lru_frame_replacer.sv =====
// lru frame replacer top level: sequencer, row of list cells, result register
// depends on lfr_pkg, lfr_cell and lru_frame_replacer_macros.svh
//
// usage
// - request beat: req_type_i / frame_id_i taken on a rising edge with start_i high
//   and busy_o low; codes are victim, pin and unpin, the unused code is a no-op
// - result beat: done_o is high for exactly one cycle with victim_valid_o,
//   victim_frame_o, unpin_dropped_o and occupancy_o; one result per request
// - order: accept edge, then apply edge, result shown in the next cycle;
//   busy_o is high for one cycle, so a new request waits until the last is applied
// - the accept edge registers a match bit in every cell; on the apply edge a pin
//   turns the match vector into a shift mask and moves the hit cell and all newer ones at once
// - the list lives in a row of NUM_FRAMES cells, oldest at cell 0; a removal
//   makes each cell at or after the hole take its newer neighbor's id
// - an append writes the cell at the current occupancy
// - reset clears occupancy, the sequencer, done and the hit bits; cell ids stay unknown and are
//   never read beyond the occupancy, so there is no clearing pass
// - the receiver cannot stall: the result register is overwritten by the next
//   result on the apply edge of the next request
`include "lru_frame_replacer_macros.svh"

module lru_frame_replacer #(
  parameter  int NUM_FRAMES = 64,
  localparam int CntW       = $clog2(NUM_FRAMES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lfr_pkg::REQ_W-1:0]   req_type_i,
  input  logic [lfr_pkg::FRAME_W-1:0] frame_id_i,
  output logic                        done_o,
  output logic                        victim_valid_o,
  output logic [lfr_pkg::FRAME_W-1:0] victim_frame_o,
  output logic                        unpin_dropped_o,
  output logic [CntW-1:0]             occupancy_o
);
  import lfr_pkg::*;

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic accept;

  // latched request
  logic [REQ_W-1:0]   req_q;
  logic [FRAME_W-1:0] frame_q;

  // occupancy
  logic [CntW-1:0] count_q, count_d;

  // cell row
  cell_ctrl_t          ctrl;
  logic [NUM_FRAMES-1:0] hit_vec;
  logic [NUM_FRAMES-1:0] shift_vec;
  logic [NUM_FRAMES-1:0] pin_mask;
  logic [FRAME_W-1:0]    id_vec  [NUM_FRAMES];
  logic [FRAME_W-1:0]    next_id [NUM_FRAMES];
  logic                  any_hit;
  logic                  full;
  logic                  empty;
  logic                  append;

  // result register
  logic               done_q;
  logic               vvalid_q, vvalid_d;
  logic [FRAME_W-1:0] vframe_q, vframe_d;
  logic               dropped_q, dropped_d;
  logic [CntW-1:0]    occ_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      frame_q <= frame_id_i;
    end
    if (busy_o) begin
      vvalid_q  <= vvalid_d;
      vframe_q  <= vframe_d;
      dropped_q <= dropped_d;
      occ_q     <= count_d;
    end
  end

  // one-hot hit vector to mask of the hit cell and every newer one
  assign pin_mask = ~(hit_vec - NUM_FRAMES'(1));
  assign any_hit  = |hit_vec;
  assign full     = (count_q == CntW'(NUM_FRAMES));
  assign empty    = (count_q == '0);

  // apply step of the sequencer
  always_comb begin
    count_d   = count_q;
    shift_vec = '0;
    append    = 1'b0;
    vvalid_d  = 1'b0;
    vframe_d  = '0;
    dropped_d = 1'b0;
    if (busy_o) begin
      case (req_q)
        REQ_VICTIM: begin
          if (!empty) begin
            vvalid_d  = 1'b1;
            vframe_d  = id_vec[0];
            shift_vec = '1;
            count_d   = count_q - CntW'(1);
          end
        end
        REQ_PIN: begin
          if (any_hit) begin
            shift_vec = pin_mask;
            count_d   = count_q - CntW'(1);
          end
        end
        REQ_UNPIN: begin
          if (!any_hit) begin
            if (full) begin
              dropped_d = 1'b1;
            end else begin
              append  = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  assign ctrl.cmp       = accept;
  assign ctrl.cmp_frame = frame_id_i;
  assign ctrl.append    = append;
  assign ctrl.app_frame = frame_q;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    if (g == NUM_FRAMES - 1) begin : g_tail
      assign next_id[g] = '0;
    end else begin : g_link
      assign next_id[g] = id_vec[g+1];
    end

    lfr_cell #(
      .IDX   (g),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .shift_i   (shift_vec[g]),
      .next_id_i (next_id[g]),
      .id_o      (id_vec[g]),
      .hit_o     (hit_vec[g])
    );
  end

  assign done_o          = done_q;
  assign victim_valid_o  = vvalid_q;
  assign victim_frame_o  = vframe_q;
  assign unpin_dropped_o = dropped_q;
  assign occupancy_o     = occ_q;

  // checks
  `LFR_ASSERT_IMPL(a_done_follows_exec, done_o, $past(busy_o))
  `LFR_ASSERT_IMPL(a_accept_to_exec, accept, ##1 busy_o)
  `LFR_ASSERT(a_count_in_range, count_q <= CntW'(NUM_FRAMES))
  `LFR_ASSERT_IMPL(a_single_hit, busy_o, $onehot0(hit_vec))

endmodule

// ===== verif/lru_frame_replacer_checker.sv =====
// checker for the lru frame replacer: watches request and result beats, keeps its
// own copy of the evictable list and compares every result in all of its fields
// depends on lfr_pkg
module lru_frame_replacer_checker #(
  parameter int NUM_FRAMES = 64,
  parameter int CntW       = $clog2(NUM_FRAMES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_o,
  input  logic [lfr_pkg::REQ_W-1:0]   req_type_i,
  input  logic [lfr_pkg::FRAME_W-1:0] frame_id_i,
  input  logic                        done_o,
  input  logic                        victim_valid_o,
  input  logic [lfr_pkg::FRAME_W-1:0] victim_frame_o,
  input  logic                        unpin_dropped_o,
  input  logic [CntW-1:0]             occupancy_o,
  output int                          fail_count_o,
  output int                          pending_o
);
  import lfr_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic               victim_valid;
    logic [FRAME_W-1:0] victim_frame;
    logic               unpin_dropped;
    logic [CntW-1:0]    occupancy;
  } replace_result_t;

  // evictable list, oldest at entry 0; only entries below listed are ever read
  logic [FRAME_W-1:0] frame_list [NUM_FRAMES];
  int unsigned        listed;

  replace_result_t    result_q [$];
  replace_result_t    want_res;
  replace_result_t    seen_res;
  int                 failures;
  int                 results_seen;

  // close the hole at pos, newer entries move one place older
  function automatic void drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < listed; i++) frame_list[i] = frame_list[i + 1];
    listed--;
  endfunction

  function automatic replace_result_t apply_request(logic [REQ_W-1:0] req,
                                                    logic [FRAME_W-1:0] frame);
    replace_result_t res;
    int unsigned     pos;
    res = '0;
    pos = listed;
    for (int unsigned i = 0; i < listed; i++) begin
      if (frame_list[i] == frame && pos == listed) pos = i;
    end
    case (req)
      REQ_VICTIM: begin
        if (listed > 0) begin
          res.victim_valid = 1'b1;
          res.victim_frame = frame_list[0];
          drop_entry(0);
        end
      end
      REQ_PIN: begin
        if (pos < listed) drop_entry(pos);
      end
      REQ_UNPIN: begin
        if (pos == listed) begin
          if (listed >= NUM_FRAMES) begin
            res.unpin_dropped = 1'b1;
          end else begin
            frame_list[listed] = frame;
            listed++;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = CntW'(listed);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listed       = 0;
      failures     = 0;
      results_seen = 0;
      result_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result beat first: it always belongs to an earlier request beat
      if (done_o) begin
        seen_res = '{victim_valid_o, victim_frame_o, unpin_dropped_o, occupancy_o};
        results_seen++;
        if (result_q.size() == 0) begin
          failures++;
          if (failures <= ReportLimit)
            $display("result beat %0d with no request outstanding: vv=%0b vf=%0d ud=%0b occ=%0d",
                     results_seen, seen_res.victim_valid, seen_res.victim_frame,
                     seen_res.unpin_dropped, seen_res.occupancy);
        end else begin
          want_res = result_q.pop_front();
          if (seen_res !== want_res) begin
            failures++;
            if (failures <= ReportLimit)
              $display("result beat %0d mismatch: want vv=%0b vf=%0d ud=%0b occ=%0d, got vv=%0b vf=%0d ud=%0b occ=%0d",
                       results_seen, want_res.victim_valid, want_res.victim_frame,
                       want_res.unpin_dropped, want_res.occupancy, seen_res.victim_valid,
                       seen_res.victim_frame, seen_res.unpin_dropped, seen_res.occupancy);
          end
        end
      end
      if (start_i && !busy_o) result_q.push_back(apply_request(req_type_i, frame_id_i));
      fail_count_o <= failures;
      pending_o    <= result_q.size();
    end
  end

endmodule

// ===== verif/tb_lru_frame_replacer.sv =====
// testbench top for the lru frame replacer: clock, reset, request stimulus, watchdog
// and verdict; checking is done by lru_frame_replacer_checker
// depends on lfr_pkg, lru_frame_replacer and lru_frame_replacer_checker
module tb_lru_frame_replacer;
  import lfr_pkg::*;

  localparam int NumFrames     = 64;
  localparam int CntW          = $clog2(NumFrames + 1);
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;
  localparam int RandomItems   = 300;
  localparam int VictimBurst   = 66;
  localparam int FullUnpins    = 4;

  // the fourth request code is not decoded by the block
  localparam logic [REQ_W-1:0] ReqUnused = 2'd3;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start_i    = 1'b0;
  logic [REQ_W-1:0]   req_type_i = REQ_VICTIM;
  logic [FRAME_W-1:0] frame_id_i = '0;
  logic               busy_o;
  logic               done_o;
  logic               victim_valid_o;
  logic [FRAME_W-1:0] victim_frame_o;
  logic               unpin_dropped_o;
  logic [CntW-1:0]    occupancy_o;

  int fail_count;
  int pending;
  int stall_cycles = 0;
  int idle_pct     = 0;
  bit filling      = 1'b0;

  // idle percentage of the sender in each phase; the receiver cannot stall
  int phase_idle [4] = '{0, 81, 20, 0};

  lru_frame_replacer #(
    .NUM_FRAMES(NumFrames)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .frame_id_i     (frame_id_i),
    .done_o         (done_o),
    .victim_valid_o (victim_valid_o),
    .victim_frame_o (victim_frame_o),
    .unpin_dropped_o(unpin_dropped_o),
    .occupancy_o    (occupancy_o)
  );

  lru_frame_replacer_checker #(
    .NUM_FRAMES(NumFrames)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .frame_id_i     (frame_id_i),
    .done_o         (done_o),
    .victim_valid_o (victim_valid_o),
    .victim_frame_o (victim_frame_o),
    .unpin_dropped_o(unpin_dropped_o),
    .occupancy_o    (occupancy_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: counts cycles with neither a request beat nor a result beat
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one request beat; idle cycles in front carry junk on the payload with start low.
  // returns right after the accepting edge, so a following call with no idle cycles
  // keeps start high without lowering it in between
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [FRAME_W-1:0] frame);
    while ($urandom_range(99) < idle_pct) begin
      start_i    <= 1'b0;
      req_type_i <= REQ_W'($urandom_range(3));
      frame_id_i <= FRAME_W'($urandom_range(NumFrames - 1));
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= req;
    frame_id_i <= frame;
    @(posedge clk_i);
    // busy_o read here still holds its value from before this edge
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // sender holds off until every outstanding result beat has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // request mix: filling leans toward unpin, draining toward victim and pin
  function automatic logic [REQ_W-1:0] pick_req(bit fill);
    int r = $urandom_range(99);
    if (r < 4) return ReqUnused;
    if (r < (fill ? 64 : 24)) return REQ_UNPIN;
    if (r < (fill ? 82 : 62)) return REQ_PIN;
    return REQ_VICTIM;
  endfunction

  initial begin
    int perm [NumFrames];
    int j;
    int tmp;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_beat(REQ_VICTIM, 6'd0);   // victim on empty list
    send_beat(REQ_PIN, 6'd5);      // pin of a frame not listed
    send_beat(REQ_UNPIN, 6'd0);
    send_beat(REQ_UNPIN, 6'd63);
    send_beat(REQ_UNPIN, 6'd0);    // already listed, no change
    send_beat(ReqUnused, 6'd42);   // unused code is a no-op
    send_beat(REQ_UNPIN, 6'd21);
    send_beat(REQ_UNPIN, 6'd42);
    send_beat(REQ_PIN, 6'd63);     // pin from the middle closes the gap
    send_beat(REQ_PIN, 6'd0);      // pin of the oldest
    send_beat(REQ_PIN, 6'd42);     // pin of the newest
    send_beat(REQ_VICTIM, 6'd63);  // frame id ignored on victim
    send_beat(REQ_VICTIM, 6'd0);   // list empty again
    send_beat(ReqUnused, 6'd63);
    send_beat(REQ_UNPIN, 6'd63);
    send_beat(REQ_VICTIM, 6'd17);
    wait_drained();

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];

      // fill sweep: every frame once in shuffled order brings the list to full
      foreach (perm[i]) perm[i] = i;
      for (int i = NumFrames - 1; i > 0; i--) begin
        j       = $urandom_range(i);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      foreach (perm[i]) send_beat(REQ_UNPIN, FRAME_W'(perm[i]));
      // unpins on a full list
      repeat (FullUnpins) send_beat(REQ_UNPIN, FRAME_W'($urandom_range(NumFrames - 1)));

      // random traffic with a drifting tide between filling and draining
      filling = 1'b0;
      repeat (RandomItems) begin
        if ($urandom_range(49) == 0) filling = !filling;
        send_beat(pick_req(filling), FRAME_W'($urandom_range(NumFrames - 1)));
      end

      // victim burst runs the list dry and keeps asking on the empty list
      repeat (VictimBurst) send_beat(REQ_VICTIM, FRAME_W'($urandom_range(NumFrames - 1)));

      // hold-off between phases
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== lru_frame_replacer.f =====
+incdir+sv
sv/lfr_pkg.sv
sv/lfr_cell.sv
sv/lru_frame_replacer.sv
verif/lru_frame_replacer_checker.sv
verif/tb_lru_frame_replacer.sv
